>>> src/hbdrv_pkg.sv
`default_nettype none

package hbdrv_pkg;

  localparam int unsigned CFG_AW = 5;

  typedef enum logic [2:0] {
    CFG_PWM_PERIOD   = 3'd0,
    CFG_USE_SENSOR   = 3'd1,
    CFG_ADC_SCALE    = 3'd2,
    CFG_RESISTANCE   = 3'd3,
    CFG_BEMF_GAIN    = 3'd4,
    CFG_FILTER_ALPHA = 3'd5,
    CFG_TORQUE_CONST = 3'd6,
    CFG_INVERT_DIR   = 3'd7
  } cfg_idx_t;

  localparam logic [1:0] CMD_DRIVE   = 2'd0;
  localparam logic [1:0] CMD_BRAKE   = 2'd1;
  localparam logic [1:0] CMD_NEUTRAL = 2'd2;

  typedef enum logic [1:0] {
    MODE_NEUTRAL = 2'd0,
    MODE_FORWARD = 2'd1,
    MODE_REVERSE = 2'd2,
    MODE_BRAKE   = 2'd3
  } drive_mode_t;

  typedef enum logic [1:0] {
    LEG_LOW  = 2'd0,
    LEG_HIGH = 2'd1,
    LEG_HIZ  = 2'd2
  } leg_t;

  localparam logic [14:0] DEADBAND      = 15'd328;
  localparam logic [15:0] DUTY_NEG_FULL = 16'h8000;
  localparam logic [15:0] DUTY_NEG_CLIP = 16'h8001;
  localparam logic [16:0] ALPHA_ONE     = 17'h10000;
  localparam logic [15:0] PERIOD_RESET  = 16'hFFFF;
  localparam logic [31:0] SAT_POS       = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG       = 32'h8000_0000;

endpackage

`default_nettype wire

>>> src/hbridge_drive_with_current_estimate.sv
`default_nettype none

// H-bridge drive with motor current estimate. Each transfer on the input channel
// carries one command and yields exactly one result transfer with the drive mode,
// both leg settings, the PWM compare count and the reported effort. All products
// come from one shared 32x32 multiplier and the quotient from a radix-2 restoring
// divider under a one-hot sequencer, and the block takes no new transfer until the
// current command has been handed to the output register. Brake, coast and
// near-zero duty commands go from decode straight to output; a drive command whose
// current estimate is skipped first passes the compare multiply; the sensor and
// back-EMF paths add estimate, filter and effort steps, the back-EMF path also 32
// divider steps unless the quotient saturates. A stalled output register holds the
// command until it can be loaded. Configuration is written over an APB-style port
// whose pready is always high; registers sit at byte address 4 times their index.
module hbridge_drive_with_current_estimate #(
  parameter int unsigned ADC_BITS = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,

  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_cmd,
  input  wire logic signed [15:0]          in_duty,
  input  wire logic [ADC_BITS-1:0]         in_adc_sample,
  input  wire logic signed [31:0]          in_shaft_velocity,
  input  wire logic [23:0]                 in_supply_voltage,

  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_drive_mode,
  output logic [1:0]                       out_leg_a_drive,
  output logic [1:0]                       out_leg_b_drive,
  output logic [15:0]                      out_compare_value,
  output logic signed [31:0]               out_effort,

  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [hbdrv_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  import hbdrv_pkg::*;

  typedef enum logic [19:0] {
    ST_IDLE  = 20'h00001,
    ST_DEC   = 20'h00002,
    ST_CMP   = 20'h00004,
    ST_SEL   = 20'h00008,
    ST_SENS  = 20'h00010,
    ST_SENS2 = 20'h00020,
    ST_VM    = 20'h00040,
    ST_BE    = 20'h00080,
    ST_NUM   = 20'h00100,
    ST_MAG   = 20'h00200,
    ST_DCHK  = 20'h00400,
    ST_DIV   = 20'h00800,
    ST_DEND  = 20'h01000,
    ST_F1    = 20'h02000,
    ST_F2    = 20'h04000,
    ST_F3    = 20'h08000,
    ST_F4    = 20'h10000,
    ST_EFF   = 20'h20000,
    ST_EFF2  = 20'h40000,
    ST_OUT   = 20'h80000
  } state_t;

  // Configuration registers.
  logic [15:0]   period_r;
  logic          use_sens_r;
  logic [23:0]   adc_scale_r;
  logic [23:0]   res_r;
  logic [23:0]   bemf_r;
  logic [16:0]   alpha_r;
  logic [23:0]   tq_r;
  logic          inv_r;

  logic          cfg_wr;
  cfg_idx_t      cfg_idx;

  // Sequencer and architectural state.
  state_t        state_r, state_nxt;
  drive_mode_t   mode_r, mode_nxt;
  logic [31:0]   effort_r, effort_nxt;
  logic [31:0]   fmag_r, fmag_nxt;
  logic          fneg_r, fneg_nxt;

  // Captured command.
  logic [1:0]          cmd_r, cmd_nxt;
  logic signed [15:0]  duty_r, duty_nxt;
  logic [14:0]         ad_r, ad_nxt;
  logic [ADC_BITS-1:0] adc_r, adc_nxt;
  logic [31:0]         omag_r, omag_nxt;
  logic                oneg_r, oneg_nxt;
  logic [23:0]         supply_r, supply_nxt;

  // Datapath working registers.
  logic [63:0]         prod_r;
  logic [31:0]         mul_a, mul_b;
  logic [15:0]         cmpv_r, cmpv_nxt;
  logic [23:0]         vm_r, vm_nxt;
  logic signed [41:0]  num_r, num_nxt;
  logic [40:0]         nmag_r, nmag_nxt;
  logic                nneg_r, nneg_nxt;
  logic [23:0]         rem_r, rem_nxt;
  logic [31:0]         dq_r, dq_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic [31:0]         imag_r, imag_nxt;
  logic                ineg_r, ineg_nxt;
  logic signed [50:0]  acc_r, acc_nxt;

  // Output register.
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_mode_r;
  logic [1:0]    out_leg_a_r;
  logic [1:0]    out_leg_b_r;
  logic [15:0]   out_cmp_r;
  logic [31:0]   out_eff_r;
  logic          out_load;

  // Combinational helpers.
  logic signed [15:0]  duty_clip;
  logic [15:0]         duty_neg;
  logic [31:0]         omega_neg;
  logic [16:0]         a_eff;
  logic [16:0]         a_cmp;
  logic signed [41:0]  vm_s;
  logic [39:0]         be_mag;
  logic signed [41:0]  be_s;
  logic signed [41:0]  num_s;
  logic signed [41:0]  num_neg;
  logic [24:0]         div_hi;
  logic [24:0]         trial;
  logic                trial_ge;
  logic [24:0]         trial_sub;
  logic signed [50:0]  p49_s;
  logic signed [50:0]  p49_n;
  logic signed [50:0]  acc_neg;
  logic [49:0]         acc_mag;
  logic [33:0]         acc_sh;
  logic [39:0]         eff_mag;
  logic [31:0]         eff_neg;
  logic                a_hiz;
  logic [1:0]          leg_a, leg_b;
  logic [15:0]         cmp_out;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = cfg_idx_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RESET;
      use_sens_r  <= 1'b0;
      adc_scale_r <= '0;
      res_r       <= '0;
      bemf_r      <= '0;
      alpha_r     <= ALPHA_ONE;
      tq_r        <= '0;
      inv_r       <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_PWM_PERIOD:   period_r    <= pwdata[15:0];
        CFG_USE_SENSOR:   use_sens_r  <= pwdata[0];
        CFG_ADC_SCALE:    adc_scale_r <= pwdata[23:0];
        CFG_RESISTANCE:   res_r       <= pwdata[23:0];
        CFG_BEMF_GAIN:    bemf_r      <= pwdata[23:0];
        CFG_FILTER_ALPHA: alpha_r     <= pwdata[16:0];
        CFG_TORQUE_CONST: tq_r        <= pwdata[23:0];
        CFG_INVERT_DIR:   inv_r       <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_PWM_PERIOD:   prdata = {16'd0, period_r};
      CFG_USE_SENSOR:   prdata = {31'd0, use_sens_r};
      CFG_ADC_SCALE:    prdata = {8'd0, adc_scale_r};
      CFG_RESISTANCE:   prdata = {8'd0, res_r};
      CFG_BEMF_GAIN:    prdata = {8'd0, bemf_r};
      CFG_FILTER_ALPHA: prdata = {15'd0, alpha_r};
      CFG_TORQUE_CONST: prdata = {8'd0, tq_r};
      CFG_INVERT_DIR:   prdata = {31'd0, inv_r};
    endcase
  end

  assign duty_clip = (in_duty == DUTY_NEG_FULL) ? DUTY_NEG_CLIP : in_duty;
  assign duty_neg  = 16'd0 - duty_clip;
  assign omega_neg = 32'd0 - in_shaft_velocity;

  assign a_eff = alpha_r[16] ? ALPHA_ONE : alpha_r;
  assign a_cmp = ALPHA_ONE - a_eff;

  assign vm_s    = duty_r[15] ? -$signed({18'd0, vm_r}) : $signed({18'd0, vm_r});
  assign be_mag  = prod_r[55:16];
  assign be_s    = oneg_r ? -$signed({2'd0, be_mag}) : $signed({2'd0, be_mag});
  assign num_s   = vm_s - be_s;
  assign num_neg = -num_r;

  assign div_hi    = nmag_r[40:16];
  assign trial     = {rem_r, dq_r[31]};
  assign trial_ge  = trial >= {1'b0, res_r};
  assign trial_sub = trial - {1'b0, res_r};

  assign p49_s   = $signed({2'd0, prod_r[48:0]});
  assign p49_n   = -p49_s;
  assign acc_neg = -acc_r;
  assign acc_mag = acc_r[50] ? acc_neg[49:0] : acc_r[49:0];
  assign acc_sh  = acc_mag[49:16];

  assign eff_mag = prod_r[55:16];
  assign eff_neg = 32'd0 - eff_mag[31:0];

  // Shared multiplier operand selection.
  always_comb begin
    unique case (state_r)
      ST_CMP: begin
        mul_a = {17'd0, ad_r};
        mul_b = {16'd0, period_r};
      end
      ST_SENS: begin
        mul_a = {{(32-ADC_BITS){1'b0}}, adc_r};
        mul_b = {8'd0, adc_scale_r};
      end
      ST_VM: begin
        mul_a = {17'd0, ad_r};
        mul_b = {8'd0, supply_r};
      end
      ST_BE: begin
        mul_a = {8'd0, bemf_r};
        mul_b = omag_r;
      end
      ST_F1: begin
        mul_a = {15'd0, a_eff};
        mul_b = imag_r;
      end
      ST_F2: begin
        mul_a = {15'd0, a_cmp};
        mul_b = fmag_r;
      end
      ST_EFF: begin
        mul_a = fmag_r;
        mul_b = {8'd0, tq_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign a_hiz = (mode_r == MODE_FORWARD) ^ inv_r;

  always_comb begin
    unique case (mode_r)
      MODE_BRAKE: begin
        leg_a   = LEG_HIGH;
        leg_b   = LEG_HIGH;
        cmp_out = period_r;
      end
      MODE_FORWARD, MODE_REVERSE: begin
        leg_a   = a_hiz ? LEG_HIZ : LEG_LOW;
        leg_b   = a_hiz ? LEG_LOW : LEG_HIZ;
        cmp_out = cmpv_r;
      end
      default: begin
        leg_a   = LEG_LOW;
        leg_b   = LEG_LOW;
        cmp_out = 16'd0;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    effort_nxt = effort_r;
    fmag_nxt   = fmag_r;
    fneg_nxt   = fneg_r;
    cmd_nxt    = cmd_r;
    duty_nxt   = duty_r;
    ad_nxt     = ad_r;
    adc_nxt    = adc_r;
    omag_nxt   = omag_r;
    oneg_nxt   = oneg_r;
    supply_nxt = supply_r;
    cmpv_nxt   = cmpv_r;
    vm_nxt     = vm_r;
    num_nxt    = num_r;
    nmag_nxt   = nmag_r;
    nneg_nxt   = nneg_r;
    rem_nxt    = rem_r;
    dq_nxt     = dq_r;
    cnt_nxt    = cnt_r;
    imag_nxt   = imag_r;
    ineg_nxt   = ineg_r;
    acc_nxt    = acc_r;
    out_load   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_cmd;
          duty_nxt   = duty_clip;
          ad_nxt     = duty_clip[15] ? duty_neg[14:0] : duty_clip[14:0];
          adc_nxt    = in_adc_sample;
          omag_nxt   = in_shaft_velocity[31] ? omega_neg : in_shaft_velocity;
          oneg_nxt   = in_shaft_velocity[31];
          supply_nxt = in_supply_voltage;
          state_nxt  = ST_DEC;
        end
      end
      ST_DEC: begin
        unique case (cmd_r)
          CMD_DRIVE: begin
            effort_nxt = {{15{duty_r[15]}}, duty_r, 1'b0};
            if (ad_r < DEADBAND) begin
              mode_nxt  = MODE_BRAKE;
              state_nxt = ST_OUT;
            end else begin
              mode_nxt  = duty_r[15] ? MODE_REVERSE : MODE_FORWARD;
              state_nxt = ST_CMP;
            end
          end
          CMD_BRAKE: begin
            effort_nxt = '0;
            fmag_nxt   = '0;
            fneg_nxt   = 1'b0;
            mode_nxt   = MODE_BRAKE;
            state_nxt  = ST_OUT;
          end
          default: begin
            fmag_nxt  = '0;
            fneg_nxt  = 1'b0;
            mode_nxt  = MODE_NEUTRAL;
            state_nxt = ST_OUT;
          end
        endcase
      end
      ST_CMP: state_nxt = ST_SEL;
      ST_SEL: begin
        cmpv_nxt = prod_r[30:15];
        if (use_sens_r && (adc_scale_r != 24'd0)) begin
          state_nxt = ST_SENS;
        end else if ((res_r != 24'd0) && (supply_r != 24'd0)) begin
          state_nxt = ST_VM;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_SENS: state_nxt = ST_SENS2;
      ST_SENS2: begin
        imag_nxt  = (prod_r[63:31] != 33'd0) ? SAT_POS : prod_r[31:0];
        ineg_nxt  = duty_r[15];
        state_nxt = ST_F1;
      end
      ST_VM: state_nxt = ST_BE;
      ST_BE: begin
        vm_nxt    = prod_r[38:15];
        state_nxt = ST_NUM;
      end
      ST_NUM: begin
        num_nxt   = num_s;
        state_nxt = ST_MAG;
      end
      ST_MAG: begin
        nmag_nxt  = num_r[41] ? num_neg[40:0] : num_r[40:0];
        nneg_nxt  = num_r[41];
        state_nxt = ST_DCHK;
      end
      ST_DCHK: begin
        if (div_hi >= {1'b0, res_r}) begin
          imag_nxt  = nneg_r ? SAT_NEG : SAT_POS;
          ineg_nxt  = nneg_r;
          state_nxt = ST_F1;
        end else begin
          rem_nxt   = div_hi[23:0];
          dq_nxt    = {nmag_r[15:0], 16'd0};
          cnt_nxt   = '1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = trial_ge ? trial_sub[23:0] : trial[23:0];
        dq_nxt  = {dq_r[30:0], trial_ge};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          state_nxt = ST_DEND;
        end
      end
      ST_DEND: begin
        if (nneg_r) begin
          imag_nxt = (dq_r > SAT_NEG) ? SAT_NEG : dq_r;
        end else begin
          imag_nxt = (dq_r > SAT_POS) ? SAT_POS : dq_r;
        end
        ineg_nxt  = nneg_r;
        state_nxt = ST_F1;
      end
      ST_F1: state_nxt = ST_F2;
      ST_F2: begin
        acc_nxt   = ineg_r ? p49_n : p49_s;
        state_nxt = ST_F3;
      end
      ST_F3: begin
        acc_nxt   = acc_r + (fneg_r ? p49_n : p49_s);
        state_nxt = ST_F4;
      end
      ST_F4: begin
        fneg_nxt = acc_r[50];
        if (acc_r[50]) begin
          fmag_nxt = (acc_sh > {2'd0, SAT_NEG}) ? SAT_NEG : acc_sh[31:0];
        end else begin
          fmag_nxt = (acc_sh > {2'd0, SAT_POS}) ? SAT_POS : acc_sh[31:0];
        end
        state_nxt = ST_EFF;
      end
      ST_EFF: state_nxt = ST_EFF2;
      ST_EFF2: begin
        if (fneg_r) begin
          effort_nxt = (eff_mag > {8'd0, SAT_NEG}) ? SAT_NEG : eff_neg;
        end else begin
          effort_nxt = (eff_mag > {8'd0, SAT_POS}) ? SAT_POS : eff_mag[31:0];
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_NEUTRAL;
      effort_r    <= '0;
      fmag_r      <= '0;
      fneg_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      effort_r    <= effort_nxt;
      fmag_r      <= fmag_nxt;
      fneg_r      <= fneg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r   <= mul_a * mul_b;
    cmd_r    <= cmd_nxt;
    duty_r   <= duty_nxt;
    ad_r     <= ad_nxt;
    adc_r    <= adc_nxt;
    omag_r   <= omag_nxt;
    oneg_r   <= oneg_nxt;
    supply_r <= supply_nxt;
    cmpv_r   <= cmpv_nxt;
    vm_r     <= vm_nxt;
    num_r    <= num_nxt;
    nmag_r   <= nmag_nxt;
    nneg_r   <= nneg_nxt;
    rem_r    <= rem_nxt;
    dq_r     <= dq_nxt;
    cnt_r    <= cnt_nxt;
    imag_r   <= imag_nxt;
    ineg_r   <= ineg_nxt;
    acc_r    <= acc_nxt;
    if (out_load) begin
      out_mode_r  <= mode_r;
      out_leg_a_r <= leg_a;
      out_leg_b_r <= leg_b;
      out_cmp_r   <= cmp_out;
      out_eff_r   <= effort_r;
    end
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_drive_mode    = out_mode_r;
  assign out_leg_a_drive   = out_leg_a_r;
  assign out_leg_b_drive   = out_leg_b_r;
  assign out_compare_value = out_cmp_r;
  assign out_effort        = out_eff_r;

endmodule

`default_nettype wire

>>> src/hbdrv_checker.sv
`default_nettype none

module hbdrv_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         out_drive_mode,
  input wire logic [1:0]         out_leg_a_drive,
  input wire logic [1:0]         out_leg_b_drive,
  input wire logic [15:0]        out_compare_value,
  input wire logic signed [31:0] out_effort
);

  import hbdrv_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_effort) &&
      $stable(out_compare_value) && $stable(out_drive_mode))
    else $error("Stalled result transfer changed.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Input was not stalled while a command was in progress.");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("Result appeared without a command in progress.");

  a_drive_legs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_drive_mode == MODE_FORWARD || out_drive_mode == MODE_REVERSE)
      |-> (out_leg_a_drive == LEG_HIZ) != (out_leg_b_drive == LEG_HIZ))
    else $error("Driving mode without exactly one leg in Hi-Z.");

endmodule

bind hbridge_drive_with_current_estimate hbdrv_checker u_hbdrv_checker (.*);

`default_nettype wire

>>> sim/hbridge_drive_with_current_estimate_tb.sv
`timescale 1ns / 1ps

module hbridge_drive_with_current_estimate_tb;
  import hbdrv_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 60;

  typedef struct {
    logic [1:0]          cmd;
    logic signed [15:0]  duty;
    logic [9:0]          adc;
    logic signed [31:0]  omega;
    logic [23:0]         supply;
  } drive_cmd_t;

  typedef struct {
    drive_mode_t         mode;
    leg_t                leg_a;
    leg_t                leg_b;
    logic [15:0]         compare;
    logic signed [31:0]  effort;
  } bridge_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = CMD_DRIVE;
  logic signed [15:0] in_duty = '0;
  logic [9:0] in_adc_sample = '0;
  logic signed [31:0] in_shaft_velocity = '0;
  logic [23:0] in_supply_voltage = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_drive_mode;
  logic [1:0] out_leg_a_drive;
  logic [1:0] out_leg_b_drive;
  logic [15:0] out_compare_value;
  logic signed [31:0] out_effort;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Shadow copy of the register file and of the drive state.
  logic [15:0] pwm_top = PERIOD_RESET;
  logic sense_en = 1'b0;
  logic [23:0] sense_scale = '0;
  logic [23:0] r_wind = '0;
  logic [23:0] kv_gain = '0;
  logic [16:0] ema_weight = ALPHA_ONE;
  logic [23:0] kt_gain = '0;
  logic swap_legs = 1'b0;
  logic signed [31:0] i_filt = '0;
  logic signed [31:0] effort_q = '0;
  drive_mode_t mode_q = MODE_NEUTRAL;

  bridge_state_t expected_bridge_q[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  hbridge_drive_with_current_estimate dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_duty(in_duty),
    .in_adc_sample(in_adc_sample),
    .in_shaft_velocity(in_shaft_velocity),
    .in_supply_voltage(in_supply_voltage),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_drive_mode(out_drive_mode),
    .out_leg_a_drive(out_leg_a_drive),
    .out_leg_b_drive(out_leg_b_drive),
    .out_compare_value(out_compare_value),
    .out_effort(out_effort),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #1 clk = ~clk;

  function automatic longint mag64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Product shifted right with truncation toward zero.
  function automatic longint mul_tz(longint a, longint b, int unsigned sh);
    longint p;
    p = (mag64(a) * mag64(b)) >> sh;
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic void update_filter(longint cur);
    longint a;
    longint f;
    longint m;
    a = (ema_weight > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(ema_weight);
    f = a * cur + (65536 - a) * longint'(i_filt);
    m = mag64(f) >> 16;
    i_filt = sat32((f < 0) ? -m : m);
    effort_q = sat32(mul_tz(i_filt, kt_gain, 16));
  endfunction

  function automatic bridge_state_t predict_bridge(drive_cmd_t c);
    bridge_state_t r;
    longint d;
    longint ad;
    longint cur;
    longint vm;
    longint be;
    longint num;
    longint q;
    logic [15:0] cmpv;
    cmpv = '0;
    if (c.cmd == CMD_BRAKE) begin
      effort_q = '0;
      i_filt = '0;
      mode_q = MODE_BRAKE;
    end else if (c.cmd != CMD_DRIVE) begin
      i_filt = '0;
      mode_q = MODE_NEUTRAL;
    end else begin
      d = c.duty;
      if (d < -32767) d = -32767;
      ad = mag64(d);
      effort_q = 32'(d * 2);
      if (ad < longint'(DEADBAND)) begin
        mode_q = MODE_BRAKE;
      end else begin
        mode_q = (d > 0) ? MODE_FORWARD : MODE_REVERSE;
        cmpv = 16'((ad * longint'(pwm_top)) >> 15);
        if (sense_en && sense_scale != 0) begin
          cur = sat32(longint'(c.adc) * longint'(sense_scale));
          if (mode_q == MODE_REVERSE) cur = -cur;
          update_filter(cur);
        end else if (r_wind != 0 && c.supply != 0) begin
          vm = mul_tz(d, longint'(c.supply), 15);
          be = mul_tz(longint'(kv_gain), c.omega, 16);
          num = vm - be;
          q = (mag64(num) << 16) / longint'(r_wind);
          update_filter(sat32((num < 0) ? -q : q));
        end
      end
    end
    r.mode = mode_q;
    r.leg_a = LEG_LOW;
    r.leg_b = LEG_LOW;
    r.compare = cmpv;
    if (mode_q == MODE_BRAKE) begin
      r.leg_a = LEG_HIGH;
      r.leg_b = LEG_HIGH;
      r.compare = pwm_top;
    end else if (mode_q == MODE_FORWARD || mode_q == MODE_REVERSE) begin
      if ((mode_q == MODE_FORWARD) ^ swap_legs) begin
        r.leg_a = LEG_HIZ;
      end else begin
        r.leg_b = LEG_HIZ;
      end
    end else begin
      r.compare = '0;
    end
    r.effort = effort_q;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    bridge_state_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bridge_q.size() == 0) begin
        $display("%0t: result transfer with nothing expected, expected none, actual %h %h %h %h %h",
                 $time, out_drive_mode, out_leg_a_drive, out_leg_b_drive,
                 out_compare_value, out_effort);
        mismatch_count++;
      end else begin
        want = expected_bridge_q.pop_front();
        check_field("drive_mode", 32'(want.mode), 32'(out_drive_mode));
        check_field("leg_a_drive", 32'(want.leg_a), 32'(out_leg_a_drive));
        check_field("leg_b_drive", 32'(want.leg_b), 32'(out_leg_b_drive));
        check_field("compare_value", 32'(want.compare), 32'(out_compare_value));
        check_field("effort", want.effort, out_effort);
      end
    end
    out_stall <= rst_n ? ($urandom_range(99) < rx_idle_pct) : 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("FAIL");
      $finish;
    end
  end

  task automatic program_register(cfg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_PWM_PERIOD:   pwm_top = value[15:0];
      CFG_USE_SENSOR:   sense_en = value[0];
      CFG_ADC_SCALE:    sense_scale = value[23:0];
      CFG_RESISTANCE:   r_wind = value[23:0];
      CFG_BEMF_GAIN:    kv_gain = value[23:0];
      CFG_FILTER_ALPHA: ema_weight = value[16:0];
      CFG_TORQUE_CONST: kt_gain = value[23:0];
      CFG_INVERT_DIR:   swap_legs = value[0];
      default: ;
    endcase
  endtask

  task automatic send_command(drive_cmd_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c.cmd;
    in_duty <= c.duty;
    in_adc_sample <= c.adc;
    in_shaft_velocity <= c.omega;
    in_supply_voltage <= c.supply;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_bridge_q.push_back(predict_bridge(c));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bridge_q.size() != 0) @(posedge clk);
  endtask

  function automatic drive_cmd_t make_cmd(logic [1:0] cmd, logic [15:0] duty, logic [9:0] adc,
                                          logic [31:0] omega, logic [23:0] supply);
    drive_cmd_t c;
    c.cmd = cmd;
    c.duty = duty;
    c.adc = adc;
    c.omega = omega;
    c.supply = supply;
    return c;
  endfunction

  function automatic drive_cmd_t random_command();
    drive_cmd_t c;
    int unsigned sel;
    sel = $urandom_range(9);
    c.cmd = (sel < 7) ? CMD_DRIVE : (sel == 7) ? CMD_BRAKE : (sel == 8) ? CMD_NEUTRAL : CMD_SPARE;
    case ($urandom_range(5))
      0: c.duty = 16'($urandom_range(700) - 350);
      1: c.duty = $urandom_range(1) ? DUTY_NEG_FULL : DUTY_NEG_CLIP;
      default: c.duty = 16'($urandom);
    endcase
    c.adc = 10'($urandom_range(1023));
    c.omega = $urandom_range(1) ? 32'($urandom) : 32'($urandom_range(1 << 20) - (1 << 19));
    c.supply = ($urandom_range(7) == 0) ? 24'd0 : 24'($urandom);
    return c;
  endfunction

  function automatic logic [31:0] pick_setting(logic [31:0] top, logic [31:0] typical);
    case ($urandom_range(5))
      0: return 32'd0;
      1: return top;
      2, 3: return $urandom_range(typical);
      default: return $urandom_range(top);
    endcase
  endfunction

  task automatic randomize_settings();
    logic [31:0] v;
    v = pick_setting(32'hFFFF, 32'hFFFF);
    program_register(CFG_PWM_PERIOD, (v == 0) ? 32'd1 : v);
    program_register(CFG_USE_SENSOR, $urandom_range(1));
    program_register(CFG_ADC_SCALE, pick_setting(32'hFF_FFFF, 32'h3FFF));
    v = pick_setting(32'hFF_FFFF, 32'hF_FFFF);
    program_register(CFG_RESISTANCE, ($urandom_range(3) != 0 && v == 0) ? 32'h1_0000 : v);
    program_register(CFG_BEMF_GAIN, pick_setting(32'hFF_FFFF, 32'h1_FFFF));
    case ($urandom_range(4))
      0: v = 32'd0;
      1: v = 32'(ALPHA_ONE);
      2: v = $urandom_range(32'h1_FFFF, 32'h1_0000);
      default: v = $urandom_range(32'h1_0000);
    endcase
    program_register(CFG_FILTER_ALPHA, v);
    program_register(CFG_TORQUE_CONST, pick_setting(32'hFF_FFFF, 32'h2_0000));
    program_register(CFG_INVERT_DIR, $urandom_range(1));
  endtask

  task automatic test_open_loop_defaults();
    send_command(make_cmd(CMD_DRIVE, DUTY_NEG_FULL, 10'd1023, 32'h7FFF_FFFF, 24'hFF_FFFF));
    send_command(make_cmd(CMD_DRIVE, 16'h7FFF, 10'd0, 32'h8000_0000, 24'd0));
    send_command(make_cmd(CMD_DRIVE, 16'd0, 10'($urandom), $urandom, 24'($urandom)));
    send_command(make_cmd(CMD_DRIVE, 16'd327, 10'($urandom), $urandom, 24'($urandom)));
    send_command(make_cmd(CMD_DRIVE, -16'sd327, 10'($urandom), $urandom, 24'($urandom)));
    send_command(make_cmd(CMD_DRIVE, 16'd328, 10'($urandom), $urandom, 24'($urandom)));
    send_command(make_cmd(CMD_DRIVE, -16'sd328, 10'($urandom), $urandom, 24'($urandom)));
    send_command(make_cmd(CMD_BRAKE, 16'h7FFF, 10'($urandom), $urandom, 24'($urandom)));
    send_command(make_cmd(CMD_NEUTRAL, 16'h7FFF, 10'($urandom), $urandom, 24'($urandom)));
    send_command(make_cmd(CMD_SPARE, 16'h4000, 10'($urandom), $urandom, 24'($urandom)));
    wait_for_results();
  endtask

  task automatic test_current_sensor();
    program_register(CFG_PWM_PERIOD, 32'd1);
    program_register(CFG_USE_SENSOR, 32'd1);
    program_register(CFG_ADC_SCALE, 32'hFF_FFFF);
    program_register(CFG_TORQUE_CONST, 32'hFF_FFFF);
    send_command(make_cmd(CMD_DRIVE, 16'd20000, 10'd1023, 32'd0, 24'd0));
    send_command(make_cmd(CMD_DRIVE, -16'sd20000, 10'd1023, 32'd0, 24'd0));
    send_command(make_cmd(CMD_DRIVE, 16'd20000, 10'd0, 32'd0, 24'd0));
    wait_for_results();
    program_register(CFG_ADC_SCALE, 32'h100);
    program_register(CFG_FILTER_ALPHA, 32'h8000);
    program_register(CFG_TORQUE_CONST, 32'h1_0000);
    send_command(make_cmd(CMD_DRIVE, 16'd9000, 10'd1023, 32'd0, 24'd0));
    send_command(make_cmd(CMD_NEUTRAL, 16'd9000, 10'd1023, 32'd0, 24'd0));
    send_command(make_cmd(CMD_DRIVE, -16'sd9000, 10'd512, 32'd0, 24'd0));
    wait_for_results();
  endtask

  task automatic test_back_emf_model();
    program_register(CFG_PWM_PERIOD, 32'(PERIOD_RESET));
    program_register(CFG_ADC_SCALE, 32'd0);
    program_register(CFG_RESISTANCE, 32'd1);
    program_register(CFG_BEMF_GAIN, 32'hFF_FFFF);
    program_register(CFG_FILTER_ALPHA, 32'h1_FFFF);
    program_register(CFG_INVERT_DIR, 32'd1);
    send_command(make_cmd(CMD_DRIVE, 16'h7FFF, 10'd0, 32'h8000_0000, 24'hFF_FFFF));
    send_command(make_cmd(CMD_DRIVE, DUTY_NEG_CLIP, 10'd0, 32'h7FFF_FFFF, 24'hFF_FFFF));
    send_command(make_cmd(CMD_DRIVE, 16'd20000, 10'd0, 32'h1_0000, 24'd0));
    wait_for_results();
    program_register(CFG_USE_SENSOR, 32'd0);
    program_register(CFG_RESISTANCE, 32'hFF_FFFF);
    program_register(CFG_BEMF_GAIN, 32'h0_4000);
    program_register(CFG_FILTER_ALPHA, 32'h4000);
    send_command(make_cmd(CMD_DRIVE, 16'd1000, 10'd0, 32'h0003_0000, 24'h0C_0000));
    send_command(make_cmd(CMD_DRIVE, -16'sd30000, 10'd0, -32'sh0005_0000, 24'h0C_0000));
    wait_for_results();
  endtask

  task automatic test_random_traffic(int unsigned tx_pct, int unsigned rx_pct, int n_items);
    int k;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (k = 0; k < n_items; k++) begin
      if (k % 50 == 0) begin
        wait_for_results();
        randomize_settings();
      end else if ($urandom_range(39) == 0) begin
        wait_for_results();
      end
      send_command(random_command());
    end
    wait_for_results();
  endtask

  initial begin
    tx_idle_pct = 11;
    rx_idle_pct = 76;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_open_loop_defaults();
    test_current_sensor();
    test_back_emf_model();
    test_random_traffic(11, 76, 250);
    test_random_traffic(76, 11, 250);
    test_random_traffic(0, 0, 250);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
src/hbdrv_pkg.sv
src/hbridge_drive_with_current_estimate.sv
src/hbdrv_checker.sv
sim/hbridge_drive_with_current_estimate_tb.sv
